@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the life grid RTL.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

@@ rtl/core/lfg_pkg.sv @@
// Shared types, sizes and codes for the life grid generation step block.
// Depends on nothing; used by every module in rtl/core.
`timescale 1ns / 1ps

package lfg_pkg;

  // Grid size in storage.
  localparam int ROWS = 16;
  localparam int COLS = 32;
  localparam int ROW_W = 4;        // bits of a row address
  localparam int COL_W = 5;        // bits of a column address
  localparam int ROW_CNT_W = 5;    // bits of the active row count
  localparam int COL_CNT_W = 6;    // bits of the active column count

  // Configuration register indexes.
  localparam logic CFG_ACTIVE_ROWS = 1'b0;
  localparam logic CFG_ACTIVE_COLS = 1'b1;

  // Item operation codes; the fourth code means nothing and is ignored.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef logic [COLS-1:0] row_bits_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic grid_changed;
    logic addr_error;
  } out_item_t;

  // Request from the sequencer to the grid memory.
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_bits_t        wr_data;
  } mem_req_t;

endpackage

@@ rtl/core/life_grid_generation_step.sv @@
// Top level of the life grid generation step block: sequencer and ports.
// Depends on lfg_pkg, lfg_grid_mem, lfg_row_unit and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Items arrive on in_item with in_valid/in_stall; a transfer happens when
// in_valid is high and in_stall is low. Every item gives one result on
// out_item with out_valid/out_stall, transferred under the same rule.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes are expected only while idle.
// Sequence: a write or read passes through an access state to its result, an
// item with an address error, the unused opcode or a step with no active rows
// goes straight to its result, and any other generation step fills and then
// sweeps the active rows: the sweep uses the single row update unit once per
// row, reading rows through the one read port of the grid memory while the
// previous row is written back.
// The block holds in_stall high from an input transfer until its result is
// loaded into the output register; it then takes the next item while that
// result waits. If the receiver stalls, a finished result waits in the
// sequencer until the output register is free.
// Reset (rst, synchronous) kills every cell, clears the change flag and sets
// the active size back to 10 rows by 20 columns.

module life_grid_generation_step (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lfg_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lfg_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [lfg_pkg::COL_CNT_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FILL,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t                             state;
  lfg_pkg::in_item_t                  item;
  logic [lfg_pkg::ROW_CNT_W-1:0]      active_rows;
  logic [lfg_pkg::COL_CNT_W-1:0]      active_cols;
  logic [lfg_pkg::ROW_CNT_W-1:0]      eff_rows;
  logic [lfg_pkg::COL_CNT_W-1:0]      eff_cols;
  lfg_pkg::row_bits_t                 col_mask;
  logic [lfg_pkg::ROW_W-1:0]          rcnt;
  lfg_pkg::row_bits_t                 prev_row;
  lfg_pkg::row_bits_t                 cur_row;
  lfg_pkg::row_bits_t                 below_row;
  lfg_pkg::row_bits_t                 new_row;
  logic                               row_changed;
  logic                               change_acc;
  logic                               last_changed;
  logic                               cell_res;
  logic                               err_res;
  logic                               in_accept;
  logic                               addr_err_now;
  logic                               last_row;
  logic                               out_free;
  lfg_pkg::mem_req_t                  mem_req;
  lfg_pkg::row_bits_t                 rd_data;
  lfg_pkg::row_bits_t                 patched_row;

  // Active size, with values above the storage size acting as the storage size.
  assign eff_rows = (active_rows > lfg_pkg::ROW_CNT_W'(lfg_pkg::ROWS))
                  ? lfg_pkg::ROW_CNT_W'(lfg_pkg::ROWS) : active_rows;
  assign eff_cols = (active_cols > lfg_pkg::COL_CNT_W'(lfg_pkg::COLS))
                  ? lfg_pkg::COL_CNT_W'(lfg_pkg::COLS) : active_cols;

  always_comb begin
    for (int c = 0; c < lfg_pkg::COLS; c++) begin
      col_mask[c] = lfg_pkg::COL_CNT_W'(c) < eff_cols;
    end
  end

  // Handshake decode.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign addr_err_now = ({1'b0, in_item.row} >= eff_rows)
                     || ({1'b0, in_item.col} >= eff_cols);

  // Row below the one being updated; dead past the last active row.
  assign last_row  = (({1'b0, rcnt} + lfg_pkg::ROW_CNT_W'(1)) == eff_rows);
  assign below_row = last_row ? '0 : rd_data;

  // Stored row with the addressed cell replaced, for a cell write.
  always_comb begin
    patched_row = rd_data;
    patched_row[item.col] = item.cell_in;
  end

  // Memory requests from the sequencer.
  always_comb begin
    mem_req = '0;
    case (state)
      ST_IDLE: begin
        mem_req.rd_en   = in_accept;
        mem_req.rd_addr = (in_item.opcode == lfg_pkg::OP_STEP) ? '0 : in_item.row;
      end
      ST_ACCESS: begin
        mem_req.wr_en   = (item.opcode == lfg_pkg::OP_WRITE);
        mem_req.wr_addr = item.row;
        mem_req.wr_data = patched_row;
      end
      ST_FILL: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = lfg_pkg::ROW_W'(1);
      end
      ST_SWEEP: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rcnt + lfg_pkg::ROW_W'(2);
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = rcnt;
        mem_req.wr_data = new_row;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  lfg_grid_mem u_grid_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  lfg_row_unit u_row_unit (
    .prev_row (prev_row),
    .cur_row  (cur_row),
    .next_row (below_row),
    .col_mask (col_mask),
    .new_row  (new_row),
    .changed  (row_changed)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_rows  <= lfg_pkg::ROW_CNT_W'(10);
      active_cols  <= lfg_pkg::COL_CNT_W'(20);
      last_changed <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lfg_pkg::CFG_ACTIVE_ROWS: active_rows <= cfg_data[lfg_pkg::ROW_CNT_W-1:0];
          lfg_pkg::CFG_ACTIVE_COLS: active_cols <= cfg_data;
          default: ;
        endcase
      end

      // The output empties after its transfer unless a new result replaces it.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            item     <= in_item;
            cell_res <= 1'b0;
            case (in_item.opcode)
              lfg_pkg::OP_WRITE,
              lfg_pkg::OP_READ: begin
                err_res <= addr_err_now;
                state   <= addr_err_now ? ST_DONE : ST_ACCESS;
              end
              lfg_pkg::OP_STEP: begin
                err_res <= 1'b0;
                if (eff_rows == '0) begin
                  last_changed <= 1'b0;
                  state        <= ST_DONE;
                end else begin
                  state <= ST_FILL;
                end
              end
              default: begin
                err_res <= 1'b0;
                state   <= ST_DONE;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          cell_res <= (item.opcode == lfg_pkg::OP_READ) && rd_data[item.col];
          state    <= ST_DONE;
        end
        ST_FILL: begin
          prev_row   <= '0;
          cur_row    <= rd_data;
          rcnt       <= '0;
          change_acc <= 1'b0;
          state      <= ST_SWEEP;
        end
        ST_SWEEP: begin
          prev_row   <= cur_row;
          cur_row    <= below_row;
          rcnt       <= rcnt + lfg_pkg::ROW_W'(1);
          change_acc <= change_acc | row_changed;
          if (last_row) begin
            last_changed <= change_acc | row_changed;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_item.cell_out     <= cell_res;
            out_item.grid_changed <= last_changed;
            out_item.addr_error   <= err_res;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Grid writes, from the sweep or a cell write, only address active rows.
  `ASSERT_IMPLY(a_wr_in_range, mem_req.wr_en, ({1'b0, mem_req.wr_addr} < eff_rows),
                "grid write outside active rows")
  // Write-back and look-ahead read never address the same row.
  `ASSERT_IMPLY(a_no_rw_clash, mem_req.wr_en && mem_req.rd_en,
                mem_req.wr_addr != mem_req.rd_addr, "read and write hit the same row")
  // The row counter stays inside the active rows while sweeping.
  `ASSERT_IMPLY(a_sweep_range, state == ST_SWEEP, ({1'b0, rcnt} < eff_rows),
                "sweep row counter out of range")
  // A new result is never loaded over one that the receiver is stalling.
  `ASSERT_CLK(a_no_overwrite, (out_valid && out_stall) |=> $stable(out_item),
              "result overwritten while stalled")

endmodule

@@ rtl/core/lfg_grid_mem.sv @@
// Grid storage: one row of cells per entry, one read and one write port.
// Depends on lfg_pkg. Rows never written since reset read as all dead.
`timescale 1ns / 1ps

module lfg_grid_mem (
  input  logic                clk,
  input  logic                rst,
  input  lfg_pkg::mem_req_t   req,
  output lfg_pkg::row_bits_t  rd_data
);

  lfg_pkg::row_bits_t            mem [lfg_pkg::ROWS];
  logic [lfg_pkg::ROWS-1:0]      row_valid;
  lfg_pkg::row_bits_t            rd_q;
  logic                          rd_valid_q;

  // Row array write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // Per-row valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_valid_q <= row_valid[req.rd_addr];
      end
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  // A row that was never written reads as dead cells.
  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

@@ rtl/core/lfg_row_unit.sv @@
// Shared row update unit: applies the B3/S23 rule to one row of cells.
// Depends on lfg_pkg. Reused for every row of a generation sweep.
`timescale 1ns / 1ps

module lfg_row_unit (
  input  lfg_pkg::row_bits_t  prev_row,
  input  lfg_pkg::row_bits_t  cur_row,
  input  lfg_pkg::row_bits_t  next_row,
  input  lfg_pkg::row_bits_t  col_mask,
  output lfg_pkg::row_bits_t  new_row,
  output logic                changed
);

  logic [lfg_pkg::COLS+1:0] up_ext;
  logic [lfg_pkg::COLS+1:0] mid_ext;
  logic [lfg_pkg::COLS+1:0] dn_ext;
  lfg_pkg::row_bits_t       rule_row;

  // Inactive columns count as dead; a dead guard bit pads each side.
  assign up_ext  = {1'b0, prev_row & col_mask, 1'b0};
  assign mid_ext = {1'b0, cur_row  & col_mask, 1'b0};
  assign dn_ext  = {1'b0, next_row & col_mask, 1'b0};

  // Neighbor count and rule, one independent lane per column.
  always_comb begin
    logic [3:0] cnt;
    for (int c = 0; c < lfg_pkg::COLS; c++) begin
      cnt = 4'(up_ext[c]) + 4'(up_ext[c+1]) + 4'(up_ext[c+2])
          + 4'(mid_ext[c]) + 4'(mid_ext[c+2])
          + 4'(dn_ext[c]) + 4'(dn_ext[c+1]) + 4'(dn_ext[c+2]);
      rule_row[c] = (cnt == 4'd3) || (mid_ext[c+1] && (cnt == 4'd2));
    end
  end

  // Cells outside the active columns keep their stored value.
  assign new_row = (rule_row & col_mask) | (cur_row & ~col_mask);
  assign changed = |((rule_row ^ cur_row) & col_mask);

endmodule
